// ===== design/abbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the alpha bounding-box crop.
// No dependencies.
package abbc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PAD_W      = 11;
    localparam int DIM_W      = 14;
    localparam int EFF_W      = 17;

    localparam logic signed [PAD_W-1:0] PAD_LIMIT = 11'sd1000;
    localparam logic [14:0]             HALF_INF  = 15'h7C00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_THRESHOLD = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_RIGHT       = 3'd2,
        REG_PAD_TOP         = 3'd3,
        REG_PAD_BOTTOM      = 3'd4,
        REG_FRAME_WIDTH     = 3'd5,
        REG_FRAME_HEIGHT    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_BAD_SIZE = 2'd2
    } status_t;

    typedef struct packed {
        logic [14:0]             alpha_threshold;
        logic signed [PAD_W-1:0] pad_left;
        logic signed [PAD_W-1:0] pad_right;
        logic signed [PAD_W-1:0] pad_top;
        logic signed [PAD_W-1:0] pad_bottom;
        logic [DIM_W-1:0]        frame_width;
        logic [DIM_W-1:0]        frame_height;
    } cfg_t;

    // Packed from the lowest bit up: status first, shift_y_halves last.
    typedef struct packed {
        logic signed [15:0] shift_y_halves;
        logic signed [15:0] shift_x_halves;
        logic [13:0]        crop_height;
        logic [13:0]        crop_width;
        logic signed [14:0] origin_y;
        logic signed [14:0] origin_x;
        logic [1:0]         status;
    } result_t;

    function automatic logic signed [PAD_W-1:0] sat_pad(logic [PAD_W-1:0] v);
        logic signed [PAD_W-1:0] s;
        s = signed'(v);
        if (s > PAD_LIMIT)
            return PAD_LIMIT;
        if (s < -PAD_LIMIT)
            return -PAD_LIMIT;
        return s;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [EFF_W-1:0] eff_dim(logic [DIM_W-1:0] d, int unsigned max_dim);
        if (d == '0)
            return EFF_W'(1);
        if (32'(d) > max_dim)
            return EFF_W'(max_dim);
        return EFF_W'(d);
    endfunction

endpackage

// ===== design/abbc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register bank: write-only, pads saturated on write.
// Depends on abbc_pkg.
module abbc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [abbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abbc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output abbc_pkg::cfg_t                      cfg
);
    import abbc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_threshold <= '0;
            cfg_reg.pad_left        <= '0;
            cfg_reg.pad_right       <= '0;
            cfg_reg.pad_top         <= '0;
            cfg_reg.pad_bottom      <= '0;
            cfg_reg.frame_width     <= DIM_W'(1);
            cfg_reg.frame_height    <= DIM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ALPHA_THRESHOLD: cfg_reg.alpha_threshold <= cfg_wdata[14:0];
                REG_PAD_LEFT:        cfg_reg.pad_left   <= sat_pad(cfg_wdata[PAD_W-1:0]);
                REG_PAD_RIGHT:       cfg_reg.pad_right  <= sat_pad(cfg_wdata[PAD_W-1:0]);
                REG_PAD_TOP:         cfg_reg.pad_top    <= sat_pad(cfg_wdata[PAD_W-1:0]);
                REG_PAD_BOTTOM:      cfg_reg.pad_bottom <= sat_pad(cfg_wdata[PAD_W-1:0]);
                REG_FRAME_WIDTH:     cfg_reg.frame_width  <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height <= cfg_wdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/abbc_box_track.sv =====
`timescale 1ns / 1ps
// Input register, raster counters and bounding-box tracking; snapshots the box
// at the end of each frame. Depends on abbc_pkg.
module abbc_box_track #(
    parameter int MAX_DIM = 8192
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  abbc_pkg::cfg_t              cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_alpha,
    input  logic                        snap_ready,
    output logic                        snap_valid,
    output logic                        snap_found,
    output logic [$clog2(MAX_DIM)-1:0]  snap_min_x,
    output logic [$clog2(MAX_DIM)-1:0]  snap_max_x,
    output logic [$clog2(MAX_DIM)-1:0]  snap_min_y,
    output logic [$clog2(MAX_DIM)-1:0]  snap_max_y
);
    import abbc_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;

    logic          in_valid_reg;
    logic [15:0]   alpha_reg;
    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic          found_reg;
    logic [CW-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic          found_next;
    logic          snap_valid_reg, snap_found_reg;
    logic [CW-1:0] snap_min_x_reg, snap_max_x_reg, snap_min_y_reg, snap_max_y_reg;

    logic          snap_free, core_en, hit, last_col, last_row, frame_end;
    logic [DW-1:0] w_eff, h_eff;

    function automatic logic half_greater(logic [15:0] a, logic [14:0] t);
        if (t > HALF_INF)
            return 1'b0;
        if (a[15])
            return 1'b0;
        if (a[14:0] > HALF_INF)
            return 1'b0;
        return a[14:0] > t;
    endfunction

    assign snap_free = !snap_valid_reg || snap_ready;
    assign core_en   = in_valid_reg && snap_free;
    assign s_tready  = !in_valid_reg || core_en;

    assign w_eff     = DW'(eff_dim(cfg.frame_width, MAX_DIM));
    assign h_eff     = DW'(eff_dim(cfg.frame_height, MAX_DIM));
    assign last_col  = {1'b0, col_reg} >= (w_eff - DW'(1));
    assign last_row  = {1'b0, row_reg} >= (h_eff - DW'(1));
    assign frame_end = last_col && last_row;
    assign hit       = half_greater(alpha_reg, cfg.alpha_threshold);

    always_comb begin
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        found_next = found_reg;
        if (hit) begin
            found_next = 1'b1;
            if (!found_reg) begin
                min_x_next = col_reg;
                max_x_next = col_reg;
                min_y_next = row_reg;
                max_y_next = row_reg;
            end else begin
                if (col_reg < min_x_reg) min_x_next = col_reg;
                if (col_reg > max_x_reg) max_x_next = col_reg;
                if (row_reg < min_y_reg) min_y_next = row_reg;
                if (row_reg > max_y_reg) max_y_next = row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (core_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            alpha_reg <= s_alpha;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            found_reg <= 1'b0;
        end else if (core_en) begin
            if (!last_col) begin
                col_reg <= CW'(col_reg + 1'b1);
            end else begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : CW'(row_reg + 1'b1);
            end
            if (frame_end) begin
                min_x_reg <= '0;
                max_x_reg <= '0;
                min_y_reg <= '0;
                max_y_reg <= '0;
                found_reg <= 1'b0;
            end else begin
                min_x_reg <= min_x_next;
                max_x_reg <= max_x_next;
                min_y_reg <= min_y_next;
                max_y_reg <= max_y_next;
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (core_en && frame_end) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_ready) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_en && frame_end) begin
            snap_found_reg <= found_next;
            snap_min_x_reg <= min_x_next;
            snap_max_x_reg <= max_x_next;
            snap_min_y_reg <= min_y_next;
            snap_max_y_reg <= max_y_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_found = snap_found_reg;
    assign snap_min_x = snap_min_x_reg;
    assign snap_max_x = snap_max_x_reg;
    assign snap_min_y = snap_min_y_reg;
    assign snap_max_y = snap_max_y_reg;

    a_box_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (core_en && frame_end) |=> (!found_reg && snap_valid_reg))
        else $error("box not cleared at frame end");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (min_x_reg <= max_x_reg && min_y_reg <= max_y_reg))
        else $error("bounding box inverted");

    a_snap_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !snap_ready) |=>
            (snap_valid_reg && $stable(snap_min_x_reg) && $stable(snap_max_y_reg)))
        else $error("frame snapshot lost under stall");

endmodule

// ===== design/abbc_crop_calc.sv =====
`timescale 1ns / 1ps
// Crop origin, size, status and centre shift from the frame snapshot, into the
// output register. Depends on abbc_pkg.
module abbc_crop_calc #(
    parameter int MAX_DIM = 8192
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  abbc_pkg::cfg_t              cfg,
    input  logic                        snap_valid,
    output logic                        snap_ready,
    input  logic                        snap_found,
    input  logic [$clog2(MAX_DIM)-1:0]  snap_min_x,
    input  logic [$clog2(MAX_DIM)-1:0]  snap_max_x,
    input  logic [$clog2(MAX_DIM)-1:0]  snap_min_y,
    input  logic [$clog2(MAX_DIM)-1:0]  snap_max_y,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output abbc_pkg::result_t           m_result
);
    import abbc_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int AW = ((CW > 12) ? CW : 12) + 4;

    logic    m_valid_reg;
    result_t res_reg, res_next;

    logic signed [AW-1:0] mnx, mxx, mny, mxy, pl, pr, pt, pb, w, h;
    logic signed [AW-1:0] ox, oy, sx, sy, hx, hy;

    assign snap_ready = !m_valid_reg || m_tready;

    assign mnx = signed'(AW'(snap_min_x));
    assign mxx = signed'(AW'(snap_max_x));
    assign mny = signed'(AW'(snap_min_y));
    assign mxy = signed'(AW'(snap_max_y));
    assign pl  = AW'(cfg.pad_left);
    assign pr  = AW'(cfg.pad_right);
    assign pt  = AW'(cfg.pad_top);
    assign pb  = AW'(cfg.pad_bottom);
    assign w   = signed'(AW'(eff_dim(cfg.frame_width, MAX_DIM)));
    assign h   = signed'(AW'(eff_dim(cfg.frame_height, MAX_DIM)));

    // 2*origin + size - frame folds to min + max + pad_far - pad_near + 1 - frame.
    assign ox = mnx - pl;
    assign oy = mny - pt;
    assign sx = mxx - mnx + pl + pr + AW'(1);
    assign sy = mxy - mny + pt + pb + AW'(1);
    assign hx = mnx + mxx + pr - pl + AW'(1) - w;
    assign hy = mny + mxy + pb - pt + AW'(1) - h;

    always_comb begin
        res_next = '0;
        if (!snap_found) begin
            res_next.status = STATUS_EMPTY;
        end else if (sx <= 0 || sy <= 0) begin
            res_next.status = STATUS_BAD_SIZE;
        end else begin
            res_next.status         = STATUS_OK;
            res_next.origin_x       = ox[14:0];
            res_next.origin_y       = oy[14:0];
            res_next.crop_width     = sx[13:0];
            res_next.crop_height    = sy[13:0];
            res_next.shift_x_halves = hx[15:0];
            res_next.shift_y_halves = hy[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_valid && snap_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.status == STATUS_OK || res_reg.status == STATUS_EMPTY ||
                         res_reg.status == STATUS_BAD_SIZE))
        else $error("illegal status code");

    a_fail_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.status != STATUS_OK) |->
            (res_reg.origin_x == '0 && res_reg.crop_width == '0 &&
             res_reg.shift_y_halves == '0))
        else $error("failed crop carries nonzero fields");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid && snap_ready) |=> m_valid_reg)
        else $error("snapshot taken but no result shown");

endmodule

// ===== design/alpha_bounding_box_crop.sv =====
`timescale 1ns / 1ps
// Top level of the alpha bounding-box crop.
// Depends on abbc_pkg, abbc_cfg_regs, abbc_box_track, abbc_crop_calc.
//
// Usage:
//   s_ channel: one beat per pixel, raster order, alpha as a half bit pattern.
//   The block counts columns and rows itself against frame_width/frame_height.
//   m_ channel: one beat per frame, issued for the frame's last pixel, giving
//   status, padded crop origin and size, and the centre shift in half pixels.
//   cfg_ port: write-only; write only while no frame is in flight.
// Timing:
//   One pixel per clock sustained while s_tready stays high. The frame's last
//   pixel reaches the result beat through the input register, the box snapshot
//   register and the output register.
// Reset (aresetn low, synchronous): counters and box clear, registers take
//   their defaults (threshold 0, pads 0, frame 1x1), no beat pending.
// Stall: when m_tready is low the result holds; pixels keep flowing until the
//   next frame end reaches the snapshot stage, then s_tready drops.
module alpha_bounding_box_crop #(
    parameter int MAX_DIM = 8192
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [abbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // alpha[15:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], origin_x[16:2], origin_y[31:17], crop_width[45:32],
    // crop_height[59:46], shift_x_halves[75:60], shift_y_halves[91:76], zero[95:92]
    output logic [95:0]                     m_tdata
);
    import abbc_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    cfg_t          cfg;
    result_t       result;
    logic          snap_valid, snap_ready, snap_found;
    logic [CW-1:0] snap_min_x, snap_max_x, snap_min_y, snap_max_y;

    abbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    abbc_box_track #(.MAX_DIM(MAX_DIM)) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_alpha    (s_tdata),
        .snap_ready (snap_ready),
        .snap_valid (snap_valid),
        .snap_found (snap_found),
        .snap_min_x (snap_min_x),
        .snap_max_x (snap_max_x),
        .snap_min_y (snap_min_y),
        .snap_max_y (snap_max_y)
    );

    abbc_crop_calc #(.MAX_DIM(MAX_DIM)) u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_found (snap_found),
        .snap_min_x (snap_min_x),
        .snap_max_x (snap_max_x),
        .snap_min_y (snap_min_y),
        .snap_max_y (snap_max_y),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {4'b0000, result};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for alpha_bounding_box_crop: directed corner pixels, saturated pads,
// then random frames under random register settings and random stalls on both sides.
// Depends on abbc_pkg and the alpha_bounding_box_crop RTL.
module tb;
    import abbc_pkg::*;

    localparam int MAX_DIM       = 8192;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PIXELS = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    class bbox_scoreboard;
        logic [14:0]      thr;
        int               pad_l, pad_r, pad_t, pad_b;
        logic [DIM_W-1:0] width_raw, height_raw;
        int               col, row, min_x, max_x, min_y, max_y;
        bit               found;
        result_t          expected_crops[$];
        int               errors, pixels, crops, writes;
        int               by_status[3];

        function new();
            thr = '0;
            pad_l = 0;
            pad_r = 0;
            pad_t = 0;
            pad_b = 0;
            width_raw = 1;
            height_raw = 1;
            col = 0;
            row = 0;
            clear_box();
            errors = 0;
            pixels = 0;
            crops = 0;
            writes = 0;
            by_status = '{0, 0, 0};
        endfunction

        function void clear_box();
            min_x = 0;
            max_x = 0;
            min_y = 0;
            max_y = 0;
            found = 1'b0;
        endfunction

        function int usable_dim(logic [DIM_W-1:0] d);
            if (d == '0)
                return 1;
            if (int'(d) > MAX_DIM)
                return MAX_DIM;
            return int'(d);
        endfunction

        function int frame_pixels();
            return usable_dim(width_raw) * usable_dim(height_raw);
        endfunction

        function int clamp_pad(logic [14:0] v);
            int s;
            s = $signed(v[PAD_W-1:0]);
            if (s > int'(PAD_LIMIT))
                return int'(PAD_LIMIT);
            if (s < -int'(PAD_LIMIT))
                return -int'(PAD_LIMIT);
            return s;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [14:0] v);
            writes++;
            case (idx)
                REG_ALPHA_THRESHOLD: thr = v;
                REG_PAD_LEFT:        pad_l = clamp_pad(v);
                REG_PAD_RIGHT:       pad_r = clamp_pad(v);
                REG_PAD_TOP:         pad_t = clamp_pad(v);
                REG_PAD_BOTTOM:      pad_b = clamp_pad(v);
                REG_FRAME_WIDTH:     width_raw = v[DIM_W-1:0];
                REG_FRAME_HEIGHT:    height_raw = v[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted pixel; queues a crop when it closes the frame.
        function void note_pixel(logic [15:0] a);
            int      w, h, ox, oy, sx, sy;
            result_t r;
            pixels++;
            w = usable_dim(width_raw);
            h = usable_dim(height_raw);
            if (thr <= HALF_INF && !a[15] && a[14:0] <= HALF_INF && a[14:0] > thr) begin
                if (!found) begin
                    min_x = col;
                    max_x = col;
                    min_y = row;
                    max_y = row;
                    found = 1'b1;
                end else begin
                    if (col < min_x) min_x = col;
                    if (col > max_x) max_x = col;
                    if (row < min_y) min_y = row;
                    if (row > max_y) max_y = row;
                end
            end
            if (col < w - 1) begin
                col++;
                return;
            end
            col = 0;
            if (row < h - 1) begin
                row++;
                return;
            end
            row = 0;
            r = '0;
            if (!found) begin
                r.status = STATUS_EMPTY;
            end else begin
                ox = min_x - pad_l;
                oy = min_y - pad_t;
                sx = max_x - min_x + pad_l + pad_r + 1;
                sy = max_y - min_y + pad_t + pad_b + 1;
                if (sx <= 0 || sy <= 0) begin
                    r.status = STATUS_BAD_SIZE;
                end else begin
                    r.status = STATUS_OK;
                    r.origin_x = 15'(ox);
                    r.origin_y = 15'(oy);
                    r.crop_width = 14'(sx);
                    r.crop_height = 14'(sy);
                    r.shift_x_halves = 16'(2 * ox + sx - w);
                    r.shift_y_halves = 16'(2 * oy + sy - h);
                end
            end
            expected_crops.push_back(r);
            clear_box();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_crop(logic [95:0] d);
            result_t got, want;
            got = d[91:0];
            if (expected_crops.size() == 0) begin
                $error("result beat with no crop expected");
                errors++;
                return;
            end
            want = expected_crops.pop_front();
            crops++;
            by_status[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("origin_x", want.origin_x, got.origin_x);
            compare_field("origin_y", want.origin_y, got.origin_y);
            compare_field("crop_width", want.crop_width, got.crop_width);
            compare_field("crop_height", want.crop_height, got.crop_height);
            compare_field("shift_x_halves", want.shift_x_halves, got.shift_x_halves);
            compare_field("shift_y_halves", want.shift_y_halves, got.shift_y_halves);
            compare_field("tdata_zero_bits", 0, d[95:92]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // alpha[15:0]
    logic                  m_tvalid;
    logic                  m_tready;
    // status[1:0], origin_x[16:2], origin_y[31:17], crop_width[45:32],
    // crop_height[59:46], shift_x_halves[75:60], shift_y_halves[91:76], zero[95:92]
    logic [95:0]           m_tdata;

    bit no_idle;
    bit hold_req;
    int stall_cycles;

    bbox_scoreboard sb = new();

    alpha_bounding_box_crop #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_crop(m_tdata);
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_pixel(input logic [15:0] alpha);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= alpha;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_crops();
        s_tvalid <= 1'b0;
        while (sb.expected_crops.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_alpha(logic [14:0] thr, int density);
        int          r;
        int unsigned t, top;
        t = thr;
        r = $urandom_range(99);
        if (r < 10)
            return 16'($urandom);
        if (r < 10 + density) begin
            if (t >= HALF_INF)
                return 16'($urandom);
            top = (t + 4 < HALF_INF && $urandom_range(1) != 0) ? t + 4 : HALF_INF;
            return {1'b0, 15'($urandom_range(top, t + 1))};
        end
        case ($urandom_range(3))
            0: return {1'b1, 15'($urandom)};
            1: return {1'b0, 15'($urandom_range(16'h7FFF, 16'h7C01))};
            default: return {1'b0, 15'($urandom_range(t > HALF_INF ? HALF_INF : t, 0))};
        endcase
    endfunction

    function automatic logic [14:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return 15'd22080;
        if (r < 25) return HALF_INF;
        if (r < 30) return 15'($urandom_range(16'h7FFF, 16'h7C01));
        if (r < 45) return 15'($urandom);
        return 15'($urandom_range(22080, 0));
    endfunction

    function automatic logic [14:0] pick_pad();
        int r, p;
        r = $urandom_range(99);
        if (r < 65)
            p = int'($urandom_range(8)) - 4;
        else if (r < 85)
            p = ($urandom_range(1) != 0) ? int'(PAD_LIMIT) : -int'(PAD_LIMIT);
        else if (r < 92)
            p = int'($urandom_range(1000)) * (($urandom_range(1) != 0) ? 1 : -1);
        else
            p = ($urandom_range(1) != 0) ? int'($urandom_range(1023, 1001))
                                          : -int'($urandom_range(1024, 1001));
        return {4'($urandom), 11'(p)};
    endfunction

    function automatic logic [14:0] pick_dim();
        return {1'($urandom), 14'(($urandom_range(99) < 6) ? 0 : $urandom_range(5, 1))};
    endfunction

    task automatic random_config(input bit all_regs);
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_ALPHA_THRESHOLD, pick_threshold());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_PAD_LEFT, pick_pad());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_PAD_RIGHT, pick_pad());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_PAD_TOP, pick_pad());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_PAD_BOTTOM, pick_pad());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_FRAME_WIDTH, pick_dim());
        if (all_regs || $urandom_range(99) < 40) write_reg(REG_FRAME_HEIGHT, pick_dim());
    endtask

    // mark_corners sends alpha 16'h3C00 on the first and last pixel of each frame, a hit under any lower threshold
    task automatic send_frames(input int frames, input bit mark_corners);
        int total, density;
        for (int f = 0; f < frames; f++) begin
            total = sb.frame_pixels();
            density = ($urandom_range(99) < 15) ? 0 : int'($urandom_range(60, 2));
            for (int i = 0; i < total; i++) begin
                if (mark_corners && (i == 0 || i == total - 1))
                    send_pixel(16'h3C00);
                else
                    send_pixel(pick_alpha(sb.thr, density));
            end
        end
    endtask

    initial begin
        int base, phase;
        logic [15:0] corner_alphas[8];
        logic [15:0] small_frame[6];
        corner_alphas = '{16'h0000, 16'h0001, 16'h7BFF, 16'h7C00,
                          16'h7C01, 16'h8000, 16'h8001, 16'hFFFF};
        small_frame = '{16'h3C00, 16'h3BFF, 16'hBC00, 16'h7E00, 16'h3C01, 16'h0000};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ALPHA_THRESHOLD;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 1x1 frames at reset defaults: zero, denormal, max finite, inf, NaN, negatives
        foreach (corner_alphas[i])
            send_pixel(corner_alphas[i]);
        drain_crops();
        write_reg(REG_ALPHA_THRESHOLD, 15'h7E00);
        send_pixel(16'h7C00);
        drain_crops();
        write_reg(REG_ALPHA_THRESHOLD, HALF_INF);
        send_pixel(16'h7C00);
        drain_crops();

        // pads shrink a single-pixel box to nothing; one pixel equals the threshold
        write_reg(REG_ALPHA_THRESHOLD, 15'h3C00);
        write_reg(REG_FRAME_WIDTH, 15'd3);
        write_reg(REG_FRAME_HEIGHT, 15'd2);
        write_reg(REG_PAD_LEFT, 15'h07FF);
        write_reg(REG_PAD_RIGHT, 15'h07FF);
        foreach (small_frame[i])
            send_pixel(small_frame[i]);
        drain_crops();

        // width shrinks below the column counter mid-frame
        write_reg(REG_PAD_LEFT, 15'd0);
        write_reg(REG_PAD_RIGHT, 15'd0);
        write_reg(REG_FRAME_WIDTH, 15'd4);
        write_reg(REG_FRAME_HEIGHT, 15'd1);
        send_pixel(16'h3C01);
        send_pixel(16'h0000);
        send_pixel(16'h4000);
        drain_crops();
        write_reg(REG_SPARE, 15'h7FFF);
        write_reg(REG_FRAME_WIDTH, 15'd2);
        send_pixel(16'h0000);
        drain_crops();

        // long row and long column with saturated pads, no idling
        no_idle = 1'b1;
        write_reg(REG_ALPHA_THRESHOLD, 15'd0);
        write_reg(REG_PAD_LEFT, {4'b1010, 11'h3FF});
        write_reg(REG_PAD_RIGHT, 15'h03E9);
        write_reg(REG_PAD_TOP, {4'b0101, 11'h3E8});
        write_reg(REG_PAD_BOTTOM, 15'h7FFF & {4'hF, 11'h3FF});
        write_reg(REG_FRAME_WIDTH, {1'b1, 14'd48});
        write_reg(REG_FRAME_HEIGHT, 15'd0);
        send_frames(1, 1'b1);
        drain_crops();
        write_reg(REG_PAD_LEFT, 15'h0400);
        write_reg(REG_PAD_TOP, 15'h0417);
        write_reg(REG_FRAME_WIDTH, {1'b1, 14'h0000});
        write_reg(REG_FRAME_HEIGHT, 15'd32);
        send_frames(1, 1'b1);
        drain_crops();
        no_idle = 1'b0;

        base = sb.pixels;
        phase = 0;
        while (sb.pixels - base < RANDOM_PIXELS) begin
            phase++;
            drain_crops();
            no_idle = (phase >= 20 && phase < 28);
            if (phase == 6) begin
                // result side holds off while 1x1 frames keep coming
                write_reg(REG_FRAME_WIDTH, 15'd1);
                write_reg(REG_FRAME_HEIGHT, 15'd1);
                hold_req = 1'b1;
                send_frames(40, 1'b0);
            end else begin
                random_config(phase == 1);
                send_frames($urandom_range(3, 1), 1'b0);
                if ($urandom_range(6) == 0 && sb.frame_pixels() > 1)
                    repeat ($urandom_range(sb.frame_pixels() - 1, 1))
                        send_pixel(pick_alpha(sb.thr, 30));
            end
        end
        no_idle = 1'b0;
        drain_crops();

        $display("Run: %0d pixels, %0d register writes, %0d crop beats checked",
                 sb.pixels, sb.writes, sb.crops);
        $display("Status mix: %0d valid, %0d empty, %0d non-positive size",
                 sb.by_status[STATUS_OK], sb.by_status[STATUS_EMPTY],
                 sb.by_status[STATUS_BAD_SIZE]);
        if (sb.errors == 0 && sb.expected_crops.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== alpha_bounding_box_crop.f =====
design/abbc_pkg.sv
design/abbc_cfg_regs.sv
design/abbc_box_track.sv
design/abbc_crop_calc.sv
design/alpha_bounding_box_crop.sv
tb/tb.sv
